[rtl/mcb_pkg.sv]
// Package for the multi-click button counter.
// Result codes, state encodings and the word types shared by the other design files.
// No dependencies.
`default_nettype none

package mcb_pkg;

	// Default number of buttons
	localparam int NUM_BUTTONS_DEF = 8;
	// Most count reports a single tick may give
	localparam int MAX_REPORTS = 8;
	localparam int NREP_W = 4;

	localparam int KIND_W = 3;
	localparam int ID_W = 8;
	localparam int CNT_W = 8;
	localparam int LEN_W = 2;
	localparam int TIME_W = 32;
	localparam int TMO_W = 16;
	localparam int ENTRY_W = CNT_W + TIME_W;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd500;
	localparam logic [CNT_W-1:0] COUNT_FULL = 8'hff;

	// Command codes
	localparam logic CMD_PRESS = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Press classes
	localparam logic [LEN_W-1:0] LEN_SHORT = 2'd0;
	localparam logic [LEN_W-1:0] LEN_MEDIUM = 2'd1;
	localparam logic [LEN_W-1:0] LEN_LONG = 2'd2;
	localparam logic [LEN_W-1:0] LEN_UNUSED = 2'd3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_SHORT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_COUNTED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_IGN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0] id;
		logic [CNT_W-1:0] count;
	} res_t;

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic push;
		logic last;
		res_t res;
	} push_t;

endpackage

`default_nettype wire

[rtl/mcb_if.sv]
// Channel interfaces for the multi-click button counter.
// Depends on mcb_pkg for the field widths.
`default_nettype none

interface mcb_in_if import mcb_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	logic [ID_W-1:0] button;
	logic [LEN_W-1:0] press_length;

	modport source (output valid, output cmd, output button, output press_length,
		input ready);
	modport sink (input valid, input cmd, input button, input press_length,
		output ready);
endinterface

interface mcb_out_if import mcb_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] event_kind;
	logic [ID_W-1:0] button_id;
	logic [CNT_W-1:0] press_count;
	logic last;

	modport source (output valid, output event_kind, output button_id,
		output press_count, output last, input ready);
	modport sink (input valid, input event_kind, input button_id,
		input press_count, input last, output ready);
endinterface

`default_nettype wire

[rtl/mcb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module mcb_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and a registered read port; read data holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/mcb_out.sv]
// Output register for the result channel of the multi-click button counter.
// Depends on mcb_pkg and mcb_if.
`default_nettype none

module mcb_out import mcb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire push_t push,
	output logic can_push,
	mcb_out_if.source out_ch
);

	logic out_vld_q;
	res_t out_q;
	logic last_q;

	assign can_push = !out_vld_q || out_ch.ready;

	// Track occupancy of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push.push) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Load the word
	always_ff @(posedge clk) begin
		if (push.push) begin
			out_q <= push.res;
			last_q <= push.last;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.event_kind = out_q.kind;
	assign out_ch.button_id = out_q.id;
	assign out_ch.press_count = out_q.count;
	assign out_ch.last = last_q;

endmodule

`default_nettype wire

[rtl/mcb_seq.sv]
// Sequencer of the multi-click button counter: read-modify-write of the
// per-button entries, tick scan, and the held-back result that gets its last flag.
// Depends on mcb_pkg, mcb_if and mcb_ram.
`default_nettype none

module mcb_seq import mcb_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mcb_in_if.sink in_ch,
	input wire logic cfg_we,
	input wire logic [TMO_W-1:0] cfg_wdata,
	input wire logic can_push,
	output push_t push
);

	localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUTTONS - 1);
	localparam logic [NREP_W-1:0] NREP_LAST = NREP_W'(MAX_REPORTS - 1);

	state_t state_q, state_d;
	logic tick_q;
	logic [ID_W-1:0] btn_q;
	logic [IDX_W-1:0] addr_q;
	logic [NREP_W-1:0] nrep_q;
	logic [TIME_W-1:0] now_q;
	logic [TMO_W-1:0] timeout_q;
	logic [NUM_BUTTONS-1:0] valid_q;
	logic rd_vld_s1;
	res_t pend_q;
	logic pend_vld_q;

	logic accept;
	logic out_range;
	logic rd_en;
	logic we;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic [CNT_W-1:0] cnt;
	logic [TIME_W-1:0] tim;
	logic [CNT_W-1:0] cnt_inc;
	logic full;
	logic due;
	logic emit;
	res_t emit_res;
	logic stall;

	mcb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_BUTTONS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(addr_q),
		.wdata(wdata),
		.re(rd_en),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign accept = in_ch.valid && in_ch.ready;
	assign out_range = {1'b0, in_ch.button} >= (ID_W + 1)'(NUM_BUTTONS);

	// Entries never written read as zero
	assign cnt = rd_vld_s1 ? rdata[ENTRY_W-1 -: CNT_W] : '0;
	assign tim = rd_vld_s1 ? rdata[TIME_W-1:0] : '0;
	assign cnt_inc = cnt + CNT_W'(1);
	assign full = cnt_inc == COUNT_FULL;
	assign due = (cnt != '0) && ((now_q - tim) >= {{(TIME_W - TMO_W){1'b0}}, timeout_q});

	// Pick the result this step would produce
	always_comb begin
		emit = 1'b0;
		emit_res = '{kind: KIND_COUNTED, id: ID_W'(addr_q), count: cnt};
		case (state_q)
			ST_EVAL: begin
				if (tick_q) begin
					emit = due;
				end else begin
					emit = full;
					emit_res.count = COUNT_FULL;
				end
			end
			ST_IGN: begin
				emit = 1'b1;
				emit_res = '{kind: KIND_IGNORED, id: btn_q, count: '0};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// A new result must first move the held one out
	assign stall = emit && pend_vld_q && !can_push;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_ch.cmd == CMD_TICK) begin
						state_d = ST_RD;
					end else if (in_ch.press_length == LEN_MEDIUM
						|| in_ch.press_length == LEN_LONG) begin
						state_d = ST_FLUSH;
					end else if (in_ch.press_length == LEN_SHORT) begin
						state_d = out_range ? ST_IGN : ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!stall) begin
					if (!tick_q || addr_q == IDX_LAST || (due && nrep_q == NREP_LAST)) begin
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_IGN: begin
				if (!stall) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_vld_q || can_push) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ch.ready = 1'b0;
		rd_en = 1'b0;
		we = 1'b0;
		wdata = '0;
		push = '{push: 1'b0, last: 1'b0, res: pend_q};
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
			end
			ST_RD: begin
				rd_en = 1'b1;
			end
			ST_EVAL: begin
				push.push = emit && pend_vld_q && can_push;
				if (!stall) begin
					if (tick_q) begin
						we = due;
					end else begin
						we = 1'b1;
						wdata = full ? '0 : {cnt_inc, now_q};
					end
				end
			end
			ST_IGN: begin
				push.push = pend_vld_q && can_push;
			end
			ST_FLUSH: begin
				push.push = pend_vld_q && can_push;
				push.last = 1'b1;
			end
			default: begin
				in_ch.ready = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q <= '0;
			timeout_q <= TIMEOUT_RESET;
			valid_q <= '0;
			pend_vld_q <= 1'b0;
			nrep_q <= '0;
			addr_q <= '0;
			tick_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (we) begin
				valid_q[addr_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tick_q <= in_ch.cmd;
						if (in_ch.cmd == CMD_TICK) begin
							now_q <= now_q + TIME_W'(1);
							addr_q <= '0;
							nrep_q <= '0;
						end else begin
							addr_q <= in_ch.button[IDX_W-1:0];
							if (in_ch.press_length != LEN_UNUSED) begin
								pend_vld_q <= 1'b1;
							end
						end
					end
				end
				ST_EVAL: begin
					if (!stall) begin
						if (emit) begin
							pend_vld_q <= 1'b1;
						end
						if (tick_q) begin
							addr_q <= addr_q + IDX_W'(1);
							if (due) begin
								nrep_q <= nrep_q + NREP_W'(1);
							end
						end
					end
				end
				ST_FLUSH: begin
					if (can_push) begin
						pend_vld_q <= 1'b0;
					end
				end
				default: begin
					tick_q <= tick_q;
				end
			endcase
		end
	end

	// Held result and read-side valid bit
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			rd_vld_s1 <= valid_q[addr_q];
		end
		if (state_q == ST_IDLE && accept) begin
			btn_q <= in_ch.button;
			pend_q <= '{kind: {1'b0, in_ch.press_length}, id: in_ch.button, count: '0};
		end else if (emit && !stall) begin
			pend_q <= emit_res;
		end
	end

endmodule

`default_nettype wire

[rtl/multi_click_button_counter.sv]
// Multi-click button counter, top level; depends on mcb_pkg, mcb_if, mcb_ram, mcb_out, mcb_seq.
// A short press is read and evaluated, or ignored when out of range; medium and long presses
// go straight to flush. A tick scans the state RAM entries in turn, one read and one evaluate
// state each. One item in work at a time, the next taken once the last word has been handed
// to the output register, so any stall on the result side also holds back new items.
// Reset clears all counts and times, the time base, and sets the timeout to 500.
`default_nettype none

module multi_click_button_counter import mcb_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mcb_in_if.sink in_ch,
	mcb_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [TMO_W-1:0] cfg_wdata
);

	push_t push;
	logic can_push;

	mcb_seq #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.can_push(can_push),
		.push(push)
	);

	mcb_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.can_push(can_push),
		.out_ch(out_ch)
	);

endmodule

`default_nettype wire
